// ===== rtl/core/affine_flat_span_texturer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the flat span texturer
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef AFFINE_FLAT_SPAN_TEXTURER_TOP_DEFINES_SVH
`define AFFINE_FLAT_SPAN_TEXTURER_TOP_DEFINES_SVH

// hold cons in the same cycle as ante
`define AFST_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// hold cons in the cycle after ante
`define AFST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/afst_pkg.sv =====
// ----------------------------------------------------------------------------
// afst_pkg
// Types, constants and helpers of the flat span texturer.
// ----------------------------------------------------------------------------
package afst_pkg;

	localparam int TEX_SIDE_LOG2   = 6;
	localparam int TEX_ADDR_W      = 2 * TEX_SIDE_LOG2;
	localparam int TEX_DEPTH       = 1 << TEX_ADDR_W;
	localparam int SHADE_DEPTH     = 256;
	localparam int MAX_SPAN_WIDTH  = 4096;
	localparam int FRAC_LQ         = 16;
	localparam int FRAC_HQ         = 20;
	localparam int OFS_W           = 12;
	localparam int WIDTH_W         = 13;

	typedef enum logic [1:0] {
		REQ_TEXEL_WR   = 2'd0,
		REQ_SHADE_WR   = 2'd1,
		REQ_SPAN_START = 2'd2,
		REQ_STEP       = 2'd3
	} req_t;

	typedef enum logic {
		REG_HQ_MODE    = 1'b0,
		REG_TEXEL_MASK = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic             fullbright;
		logic [OFS_W-1:0] offset;
		logic             last;
	} pix_ctl_t;

	function automatic logic [63:0] fit_mode(input logic hq, input logic [63:0] x);
		return hq ? x : {32'd0, x[31:0]};
	endfunction

endpackage

// ===== rtl/core/affine_flat_span_texturer_top.sv =====
// ----------------------------------------------------------------------------
// affine_flat_span_texturer_top
// Affine span texturer for a 64x64 flat with a 256-entry shade colormap.
// ----------------------------------------------------------------------------
// Input stream (s_*): tuser carries the request kind. Texel and shade writes
// load the texture RAM and the colormap RAM; a span start latches U, V, their
// steps, the width (saturated to MAX_SPAN_WIDTH) and the fullbright flag; each
// step produces one pixel while pixels remain, otherwise nothing.
// Output stream (m_*): one transfer per producing step, offsets counting down
// from width-1, tlast on offset zero.
// A step's pixel passes the texture RAM read, the colormap RAM read and the
// output register before it shows on m_*.
// Throughput: one item per clock while the receiver does not stall; the two
// RAM read ports and the U/V adders are each fully pipelined.
// A stalled receiver freezes the whole pipe and drops s_tready in that cycle.
// Config port: cfg_we writes register cfg_index (0 hq_mode, 1 texel_mask);
// the user must write it only while the block is idle; the block does not enforce it.
// Reset clears accumulators, steps, the pixel count, fullbright and the
// pipe; RAM contents stay undefined until written.
// ----------------------------------------------------------------------------
`include "affine_flat_span_texturer_top_defines.svh"

module affine_flat_span_texturer_top
	import afst_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_SPAN_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// table_addr[11:0], table_data[19:12], u_start[83:20], v_start[147:84],
	// u_step[211:148], v_step[275:212], span_width[288:276], fullbright[289]
	input  logic [295:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pixel[7:0], pixel_offset[19:8]
	output logic [23:0]  m_tdata,
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [11:0]  cfg_wdata
);

	localparam int PL_W = $clog2(MAX_WIDTH + 1);

	logic [TEX_ADDR_W-1:0] table_addr;
	logic [7:0]            table_data;
	logic [63:0]           u_start, v_start, u_step, v_step;
	logic [WIDTH_W-1:0]    span_width;
	logic                  fullbright;
	req_t                  req;

	assign table_addr = s_tdata[11:0];
	assign table_data = s_tdata[19:12];
	assign u_start    = s_tdata[83:20];
	assign v_start    = s_tdata[147:84];
	assign u_step     = s_tdata[211:148];
	assign v_step     = s_tdata[275:212];
	assign span_width = s_tdata[288:276];
	assign fullbright = s_tdata[289];
	assign req        = req_t'(s_tuser);

	logic                  hq_mode_q;
	logic [TEX_ADDR_W-1:0] texel_mask_q;
	logic [63:0]           u_accum_q, v_accum_q, u_delta_q, v_delta_q;
	logic [PL_W-1:0]       pixels_left_q;
	logic                  span_fb_q;

	logic                  s1_valid_q, s2_valid_q, out_valid_q;
	pix_ctl_t              s1_ctl_q, s2_ctl_q;
	logic [7:0]            s2_raw_q;
	logic [7:0]            out_pixel_q;
	logic [OFS_W-1:0]      out_offset_q;
	logic                  out_last_q;

	logic                  adv, accept, step_fire;
	logic [PL_W-1:0]       offset;
	logic [PL_W-1:0]       width_sat;
	logic [TEX_SIDE_LOG2-1:0] iu, iv;
	logic [TEX_ADDR_W-1:0] texel_idx;
	logic [7:0]            tex_rdata, shade_rdata;
	pix_ctl_t              s0_ctl;

	assign adv       = !out_valid_q || m_tready;
	assign s_tready  = adv;
	assign accept    = s_tvalid && adv;
	assign step_fire = accept && (req == REQ_STEP) && (pixels_left_q != '0);
	assign offset    = pixels_left_q - PL_W'(1);
	assign width_sat = (span_width > WIDTH_W'(MAX_WIDTH)) ? PL_W'(MAX_WIDTH)
	                                                      : PL_W'(span_width);

	always_comb begin
		if (hq_mode_q) begin
			iu = u_accum_q[FRAC_HQ +: TEX_SIDE_LOG2];
			iv = v_accum_q[FRAC_HQ +: TEX_SIDE_LOG2];
		end else begin
			iu = u_accum_q[FRAC_LQ +: TEX_SIDE_LOG2];
			iv = v_accum_q[FRAC_LQ +: TEX_SIDE_LOG2];
		end
		texel_idx         = {iu, iv} & texel_mask_q;
		s0_ctl.fullbright = span_fb_q;
		s0_ctl.offset     = OFS_W'(offset);
		s0_ctl.last       = (offset == '0);
	end

	afst_ram #(.WIDTH(8), .DEPTH(TEX_DEPTH)) u_tex_ram (
		.clk   (clk),
		.we    (accept && (req == REQ_TEXEL_WR)),
		.waddr (table_addr),
		.wdata (table_data),
		.re    (adv),
		.raddr (texel_idx),
		.rdata (tex_rdata)
	);

	afst_ram #(.WIDTH(8), .DEPTH(SHADE_DEPTH)) u_shade_ram (
		.clk   (clk),
		.we    (accept && (req == REQ_SHADE_WR)),
		.waddr (table_addr[$clog2(SHADE_DEPTH)-1:0]),
		.wdata (table_data),
		.re    (adv),
		.raddr (tex_rdata),
		.rdata (shade_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hq_mode_q    <= 1'b0;
			texel_mask_q <= '1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_HQ_MODE:    hq_mode_q    <= cfg_wdata[0];
				REG_TEXEL_MASK: texel_mask_q <= cfg_wdata[TEX_ADDR_W-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_accum_q     <= '0;
			v_accum_q     <= '0;
			u_delta_q     <= '0;
			v_delta_q     <= '0;
			pixels_left_q <= '0;
			span_fb_q     <= 1'b0;
		end else if (accept && (req == REQ_SPAN_START)) begin
			u_accum_q     <= fit_mode(hq_mode_q, u_start);
			v_accum_q     <= fit_mode(hq_mode_q, v_start);
			u_delta_q     <= fit_mode(hq_mode_q, u_step);
			v_delta_q     <= fit_mode(hq_mode_q, v_step);
			pixels_left_q <= width_sat;
			span_fb_q     <= fullbright;
		end else if (step_fire) begin
			u_accum_q     <= fit_mode(hq_mode_q, u_accum_q + u_delta_q);
			v_accum_q     <= fit_mode(hq_mode_q, v_accum_q + v_delta_q);
			pixels_left_q <= offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q  <= step_fire;
			s2_valid_q  <= s1_valid_q;
			out_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_ctl_q     <= s0_ctl;
			s2_ctl_q     <= s1_ctl_q;
			s2_raw_q     <= tex_rdata;
			out_pixel_q  <= s2_ctl_q.fullbright ? s2_raw_q : shade_rdata;
			out_offset_q <= s2_ctl_q.offset;
			out_last_q   <= s2_ctl_q.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_offset_q, out_pixel_q};
	assign m_tlast  = out_last_q;

	`AFST_ASSERT_NEXT(a_step_enters, step_fire, s1_valid_q, "step did not enter pipe")
	`AFST_ASSERT_NEXT(a_s2_to_out, s2_valid_q && adv, out_valid_q, "pixel lost at output")
	`AFST_ASSERT_SAME(a_left_bound, 1'b1, pixels_left_q <= PL_W'(MAX_WIDTH),
		"pixel count above max width")
	`AFST_ASSERT_SAME(a_last_zero, m_tvalid && m_tlast, m_tdata[19:8] == '0,
		"tlast on nonzero offset")

endmodule

// ===== rtl/core/afst_ram.sv =====
// ----------------------------------------------------------------------------
// afst_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module afst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== dv/affine_flat_span_texturer_top_checker.sv =====
// ----------------------------------------------------------------------------
// affine_flat_span_texturer_top_checker
// Watches the request, pixel and register channels of the span texturer,
// keeps its own copy of the texture store, colormap and U/V walk, predicts
// each pixel from the accepted requests and compares the pixel stream field
// by field against the predictions, in order.
// ----------------------------------------------------------------------------
module affine_flat_span_texturer_top_checker
	import afst_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [295:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [23:0]  m_tdata,
	input  logic         m_tlast,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [11:0]  cfg_wdata,
	output int           mismatches,
	output int           pixels_due
);

	typedef struct packed {
		logic [5:0]          pad;
		logic                fullbright;
		logic [WIDTH_W-1:0]  width;
		logic [63:0]         v_step;
		logic [63:0]         u_step;
		logic [63:0]         v_start;
		logic [63:0]         u_start;
		logic [7:0]          data;
		logic [TEX_ADDR_W-1:0] addr;
	} span_req_t;

	typedef struct packed {
		logic [7:0]       pixel;
		logic [OFS_W-1:0] offset;
		logic             last;
	} span_pixel_t;

	logic [7:0]         texels [TEX_DEPTH];
	logic [7:0]         shades [SHADE_DEPTH];
	logic [63:0]        u_pos, v_pos, u_inc, v_inc;
	logic [WIDTH_W-1:0] remaining;
	logic               bright;
	logic               hq;
	logic [11:0]        tmask;
	span_pixel_t        pending_pixels [$];

	function automatic logic [63:0] to_mode(input logic [63:0] x);
		return hq ? x : {32'd0, x[31:0]};
	endfunction

	task automatic report(input string msg);
		$display("[%0t] %s", $time, msg);
		mismatches++;
	endtask

	task automatic rasterize_request(input req_t kind, input span_req_t r);
		logic [TEX_SIDE_LOG2-1:0] iu, iv;
		logic [TEX_ADDR_W-1:0]    tex_idx;
		logic [7:0]               raw;
		span_pixel_t              p;
		int                       frac;
		case (kind)
			REQ_TEXEL_WR: begin
				texels[r.addr] = r.data;
			end
			REQ_SHADE_WR: begin
				shades[r.addr[7:0]] = r.data;
			end
			REQ_SPAN_START: begin
				u_pos = to_mode(r.u_start);
				v_pos = to_mode(r.v_start);
				u_inc = to_mode(r.u_step);
				v_inc = to_mode(r.v_step);
				remaining = (r.width > WIDTH_W'(MAX_SPAN_WIDTH)) ? WIDTH_W'(MAX_SPAN_WIDTH)
					: r.width;
				bright = r.fullbright;
			end
			default: begin
				if (remaining != 0) begin
					frac = hq ? FRAC_HQ : FRAC_LQ;
					iu = TEX_SIDE_LOG2'(u_pos >> frac);
					iv = TEX_SIDE_LOG2'(v_pos >> frac);
					tex_idx = {iu, iv} & tmask;
					raw = texels[tex_idx];
					p.pixel = bright ? raw : shades[raw];
					p.offset = OFS_W'(remaining - 1'b1);
					p.last = (remaining == 1);
					u_pos = to_mode(u_pos + u_inc);
					v_pos = to_mode(v_pos + v_inc);
					remaining = remaining - 1'b1;
					pending_pixels.push_back(p);
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		span_pixel_t got, want;
		if (!arst_n) begin
			u_pos = '0;
			v_pos = '0;
			u_inc = '0;
			v_inc = '0;
			remaining = '0;
			bright = 1'b0;
			hq = 1'b0;
			tmask = 12'hFFF;
			pending_pixels.delete();
			pixels_due <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[7:0], m_tdata[19:8], m_tlast};
				if (pending_pixels.size() == 0) begin
					report($sformatf("unexpected pixel %0d at offset %0d", got.pixel, got.offset));
				end else begin
					want = pending_pixels.pop_front();
					if (got.pixel !== want.pixel)
						report($sformatf("pixel: got %0d, expected %0d (offset %0d)",
							got.pixel, want.pixel, want.offset));
					if (got.offset !== want.offset)
						report($sformatf("pixel_offset: got %0d, expected %0d",
							got.offset, want.offset));
					if (got.last !== want.last)
						report($sformatf("span_last: got %0b, expected %0b (offset %0d)",
							got.last, want.last, want.offset));
				end
			end
			if (s_tvalid && s_tready)
				rasterize_request(req_t'(s_tuser), span_req_t'(s_tdata));
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_HQ_MODE:    hq = cfg_wdata[0];
					REG_TEXEL_MASK: tmask = cfg_wdata;
					default:        ;
				endcase
			end
			pixels_due <= pending_pixels.size();
		end
	end

endmodule

// ===== dv/affine_flat_span_texturer_top_tb.sv =====
// ----------------------------------------------------------------------------
// affine_flat_span_texturer_top_tb
// Fills every texel the texel masks can reach and every colormap entry a
// texel can name, runs directed spans at the coordinate extremes, then random
// spans under several accumulator modes and texel masks, with random gaps on
// both streams; a checker predicts every pixel.
// ----------------------------------------------------------------------------
module affine_flat_span_texturer_top_tb;
	import afst_pkg::*;

	localparam int          DRAIN_CYCLES    = 8;
	localparam int          STALL_LIMIT     = 1000;
	localparam int          PHASE_ITEMS     = 40;
	localparam int          PHASES          = 6;
	localparam logic [11:0] LOAD_MASK       = 12'hC63;
	localparam logic [7:0]  TEXEL_DATA_MASK = 8'hC3;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [295:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;
	logic         m_tlast;
	logic         cfg_we;
	logic         cfg_index;
	logic [11:0]  cfg_wdata;

	int           mismatches;
	int           pixels_due;
	int           tx_quiet;
	int           rx_quiet;
	int           counted;
	int           stalled;
	logic [12:0]  span_left;

	affine_flat_span_texturer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	affine_flat_span_texturer_top_checker pixel_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pixels_due (pixels_due)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int draw_gap(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			quiet = $urandom_range(10, 40);
		return $urandom_range(0, 12);
	endfunction

	function automatic logic [63:0] rand_fixed();
		logic [63:0] x;
		x = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return x;
			1: return 64'($signed(x[23:0]));
			2: begin
				case ($urandom_range(0, 3))
					0: return 64'd0;
					1: return 64'h7FFF_FFFF_FFFF_FFFF;
					2: return 64'h8000_0000_0000_0000;
					default: return '1;
				endcase
			end
			default: return $signed(x) >>> $urandom_range(12, 56);
		endcase
	endfunction

	function automatic logic [7:0] rand_texel();
		return 8'($urandom) & TEXEL_DATA_MASK;
	endfunction

	task automatic send(input req_t kind, input logic [11:0] addr = '0,
		input logic [7:0] data = '0, input logic [63:0] us = '0, input logic [63:0] vs = '0,
		input logic [63:0] ud = '0, input logic [63:0] vd = '0, input logic [12:0] w = '0,
		input logic fb = 1'b0);
		int gap;
		gap = draw_gap(tx_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tuser <= kind;
		s_tdata <= {6'd0, fb, w, vd, ud, vs, us, data, addr};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (kind != REQ_STEP || span_left != 0)
			counted++;
		if (kind == REQ_SPAN_START)
			span_left = (w > 13'(MAX_SPAN_WIDTH)) ? 13'(MAX_SPAN_WIDTH) : w;
		else if (kind == REQ_STEP && span_left != 0)
			span_left--;
	endtask

	task automatic configure(input logic hq, input logic [11:0] mask);
		cfg_index <= REG_HQ_MODE;
		cfg_wdata <= {11'd0, hq};
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_index <= REG_TEXEL_MASK;
		cfg_wdata <= mask;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pixels_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int target);
		logic [12:0] w;
		int          extra;
		counted = 0;
		repeat (3) send(REQ_STEP);
		while (counted < target) begin
			case ($urandom_range(0, 9))
				0: send(req_t'($urandom_range(0, 3)), 12'($urandom), rand_texel(), rand_fixed(),
					rand_fixed(), rand_fixed(), rand_fixed(),
					($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 20)),
					1'($urandom_range(0, 1)));
				1: send(REQ_TEXEL_WR, 12'($urandom), rand_texel());
				2: send(REQ_SHADE_WR, 12'($urandom), 8'($urandom));
				default: begin
					case ($urandom_range(0, 19))
						0, 1: w = '0;
						2: w = 13'($urandom_range(13, 40));
						default: w = 13'($urandom_range(1, 12));
					endcase
					extra = $urandom_range(0, 2);
					send(REQ_SPAN_START, 12'($urandom), 8'($urandom), rand_fixed(), rand_fixed(),
						rand_fixed(), rand_fixed(), w, 1'($urandom_range(0, 1)));
					for (int i = 0; i < w + extra; i++) begin
						if ($urandom_range(0, 11) == 0)
							send(req_t'($urandom_range(0, 1)), 12'($urandom), rand_texel());
						send(REQ_STEP);
					end
				end
			endcase
		end
		// leave a span open across the next register change
		send(REQ_SPAN_START, '0, '0, rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed(),
			13'($urandom_range(6, 14)), 1'($urandom_range(0, 1)));
		repeat (2) send(REQ_STEP);
	endtask

	initial begin
		int gap;
		m_tready = 1'b0;
		forever begin
			gap = draw_gap(rx_quiet);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				stalled <= 0;
			else
				stalled <= stalled + 1;
			if (stalled >= STALL_LIMIT) begin
				$display("** affine_flat_span_texturer_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		logic        hq_plan [PHASES];
		logic [11:0] mask_plan [PHASES];
		hq_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		mask_plan = '{LOAD_MASK, 12'h000, 12'h000, 12'h000, 12'h000, LOAD_MASK};
		mask_plan[3] = 12'($urandom) & LOAD_MASK;
		mask_plan[4] = 12'($urandom) & LOAD_MASK;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_TEXEL_WR;
		cfg_we = 1'b0;
		cfg_index = REG_HQ_MODE;
		cfg_wdata = '0;
		span_left = '0;
		tx_quiet = 0;
		rx_quiet = 0;
		stalled = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		configure(1'b0, LOAD_MASK);

		// load every texel the masks can reach and every colormap entry a texel can name before anything reads them
		for (int a = 0; a < TEX_DEPTH; a++)
			if ((12'(a) & ~LOAD_MASK) == '0)
				send(REQ_TEXEL_WR, 12'(a), rand_texel());
		for (int a = 0; a < SHADE_DEPTH; a++)
			if ((8'(a) & ~TEXEL_DATA_MASK) == '0)
				send(REQ_SHADE_WR, {4'($urandom), 8'(a)}, 8'($urandom));

		send(REQ_STEP);
		send(REQ_SPAN_START, '0, '0, '0, '0, '0, '0, 13'd0, 1'b0);
		send(REQ_STEP);
		send(REQ_SPAN_START, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 13'd1, 1'b0);
		repeat (2) send(REQ_STEP);
		send(REQ_SPAN_START, '0, '0, '1, '1, 64'h1_0000, -64'sh1_0000, 13'd3, 1'b1);
		repeat (3) send(REQ_STEP);
		send(REQ_SHADE_WR, 12'hFFF, 8'hFF);
		send(REQ_TEXEL_WR, 12'hFFF, 8'h00);
		send(REQ_TEXEL_WR, 12'h000, 8'hFF);
		send(REQ_SPAN_START, '0, '0, '0, '0, '0, '0, 13'h1FFF, 1'b0);
		repeat (2) send(REQ_STEP);
		send(REQ_SPAN_START, '0, '0, 64'h3F_FFFF, 64'h3F_0000, 64'h1_0000, '1, 13'd2, 1'b1);
		repeat (3) send(REQ_STEP);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			configure(hq_plan[p], mask_plan[p]);
			run_phase(PHASE_ITEMS);
		end

		// open a span of the largest width, offsets counting down from 4095
		settle();
		configure(1'b1, LOAD_MASK);
		send(REQ_SPAN_START, '0, '0, rand_fixed(), rand_fixed(), 64'h4_0000, -64'sh3_0000,
			13'd4096, 1'b0);
		repeat (6) send(REQ_STEP);

		settle();
		if (mismatches == 0 && pixels_due == 0)
			$display("** affine_flat_span_texturer_top: PASSED **");
		else
			$display("** affine_flat_span_texturer_top: FAILED **");
		$finish;
	end

endmodule
